[hdl/jts_pkg.sv]
// ----------------------------------------------------------------------------
// jts_pkg
// Types, codes and helper functions of the JSON token scanner.
// ----------------------------------------------------------------------------
package jts_pkg;

  typedef enum logic [3:0] {
    MODE_START     = 4'd0,
    MODE_STRING    = 4'd1,
    MODE_ESCAPE    = 4'd2,
    MODE_UNICODE   = 4'd3,
    MODE_INT       = 4'd4,
    MODE_FRAC      = 4'd5,
    MODE_EXP       = 4'd6,
    MODE_EXP_NOFRAC = 4'd7,
    MODE_WORD      = 4'd8
  } mode_t;

  localparam logic [1:0] KIND_VALUE = 2'd0;
  localparam logic [1:0] KIND_TOKEN = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [3:0] TOK_NONE     = 4'd0;
  localparam logic [3:0] TOK_EOF      = 4'd1;
  localparam logic [3:0] TOK_STRING   = 4'd2;
  localparam logic [3:0] TOK_INTEGER  = 4'd3;
  localparam logic [3:0] TOK_FRACTION = 4'd4;
  localparam logic [3:0] TOK_WORD_BASE = 4'd4;
  localparam logic [3:0] TOK_LBRACKET = 4'd8;
  localparam logic [3:0] TOK_RBRACKET = 4'd9;
  localparam logic [3:0] TOK_COMMA    = 4'd10;
  localparam logic [3:0] TOK_LBRACE   = 4'd11;
  localparam logic [3:0] TOK_RBRACE   = 4'd12;
  localparam logic [3:0] TOK_COLON    = 4'd13;

  localparam logic [4:0] ERR_READ          = 5'd1;
  localparam logic [4:0] ERR_BAD_CHAR      = 5'd2;
  localparam logic [4:0] ERR_BAD_UTF8      = 5'd3;
  localparam logic [4:0] ERR_BELOW_SPACE   = 5'd4;
  localparam logic [4:0] ERR_ABOVE_MAX     = 5'd5;
  localparam logic [4:0] ERR_ESC_MISSING   = 5'd6;
  localparam logic [4:0] ERR_ESC_INVALID   = 5'd7;
  localparam logic [4:0] ERR_UNI_UNFINISHED = 5'd8;
  localparam logic [4:0] ERR_BAD_HEX       = 5'd9;
  localparam logic [4:0] ERR_LEAD_PERIOD   = 5'd10;
  localparam logic [4:0] ERR_LEAD_PLUS     = 5'd11;
  localparam logic [4:0] ERR_LEAD_ZERO     = 5'd12;
  localparam logic [4:0] ERR_LONE_SIGN     = 5'd13;
  localparam logic [4:0] ERR_FRAC_NODIG    = 5'd14;
  localparam logic [4:0] ERR_EXP_NODIG     = 5'd15;
  localparam logic [4:0] ERR_EXP_TWO_SIGNS = 5'd16;
  localparam logic [4:0] ERR_EXP_LATE_SIGN = 5'd17;
  localparam logic [4:0] ERR_BAD_WORD      = 5'd18;

  localparam int MaxRecords = 6;
  localparam int PassCount  = 4;

  localparam logic [20:0] CpMin = 21'h000020;
  localparam logic [23:0] CpMax = 24'h10FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  ttype;
    logic [31:0] bytes;
    logic [2:0]  cnt;
    logic [4:0]  code;
  } rec_t;

  function automatic rec_t mk_rec(logic [1:0] kind, logic [3:0] ttype, logic [31:0] bytes,
                                  logic [2:0] cnt, logic [4:0] code);
    rec_t r;
    r.kind  = kind;
    r.ttype = ttype;
    r.bytes = bytes;
    r.cnt   = cnt;
    r.code  = code;
    return r;
  endfunction

  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") r = {1'b1, 4'(c - 8'h30)};
    else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - 8'h57)};
    else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic logic [7:0] word_char(logic [1:0] id, logic [2:0] pos);
    logic [7:0] r;
    r = 8'h00;
    case (id)
      2'd1: case (pos)
        3'd0: r = "t"; 3'd1: r = "r"; 3'd2: r = "u"; 3'd3: r = "e";
        default: r = 8'h00;
      endcase
      2'd2: case (pos)
        3'd0: r = "f"; 3'd1: r = "a"; 3'd2: r = "l"; 3'd3: r = "s"; 3'd4: r = "e";
        default: r = 8'h00;
      endcase
      2'd3: case (pos)
        3'd0: r = "n"; 3'd1: r = "u"; 3'd2: r = "l"; 3'd3: r = "l";
        default: r = 8'h00;
      endcase
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] word_len(logic [1:0] id);
    logic [2:0] r;
    case (id)
      2'd1: r = 3'd4;
      2'd2: r = 3'd5;
      2'd3: r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [34:0] utf8_encode(logic [20:0] cp);
    logic [34:0] r;
    if (cp < 21'h80) r = {3'd1, 24'd0, 1'b0, cp[6:0]};
    else if (cp < 21'h800)
      r = {3'd2, 16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
    else if (cp < 21'h10000)
      r = {3'd3, 8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
    else
      r = {3'd4, 2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110, cp[20:18]};
    return r;
  endfunction

endpackage

[hdl/jts_in_if.sv]
// ----------------------------------------------------------------------------
// jts_in_if
// Character channel of the JSON token scanner.
// ----------------------------------------------------------------------------
interface jts_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] char_bytes;
  logic [2:0]  byte_count;
  logic        end_of_input;
  logic        read_error;

  modport source (output valid, char_bytes, byte_count, end_of_input, read_error,
                  input ready);
  modport sink (input valid, char_bytes, byte_count, end_of_input, read_error,
                output ready);
endinterface

[hdl/jts_out_if.sv]
// ----------------------------------------------------------------------------
// jts_out_if
// Record channel of the JSON token scanner.
// ----------------------------------------------------------------------------
interface jts_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [3:0]  token_type;
  logic [31:0] value_bytes;
  logic [2:0]  value_count;
  logic [4:0]  error_code;
  logic        last;

  modport source (output valid, record_kind, token_type, value_bytes, value_count,
                  error_code, last, input ready);
  modport sink (input valid, record_kind, token_type, value_bytes, value_count,
                error_code, last, output ready);
endinterface

[hdl/json_token_scanner_core.sv]
// ----------------------------------------------------------------------------
// json_token_scanner_core
// JSON lexer over a stream of UTF-8 characters, one character per transaction.
// ----------------------------------------------------------------------------
// Each accepted character is scanned in the cycle it arrives: the scanner state
// advances at once and the zero to six records it causes are loaded into a
// record buffer that drains one record per cycle while the output is ready. A
// character is taken when the buffer is empty or hands out its last record,
// so with a ready output characters causing at most one record each go at one
// per cycle; one causing more holds the input until its last record is taken.
// Characters that cause no record (blanks, string openers) give no output.
module json_token_scanner_core
  import jts_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  jts_in_if.sink    char_in,
  jts_out_if.source rec_out
);

  mode_t       scan_mode, scan_mode_next;
  logic [23:0] hex_accum, hex_accum_next;
  logic [2:0]  hex_digit_count, hex_digit_count_next;
  logic        hex_all_valid, hex_all_valid_next;
  logic [7:0]  number_lead_char, number_lead_char_next;
  logic [7:0]  held_byte, held_byte_next;
  logic        held_valid, held_valid_next;
  logic        lone_zero_pending, lone_zero_pending_next;
  logic        digits_seen, digits_seen_next;
  logic        is_fraction, is_fraction_next;
  logic        exp_sign_seen, exp_sign_seen_next;
  logic [4:0]  word_progress, word_progress_next;

  rec_t [MaxRecords-1:0] rec_list, rec_list_next;
  logic [2:0]            rec_count, rec_count_next;
  logic [2:0]            rec_idx;

  logic accept, take;

  task automatic push(inout rec_t [MaxRecords-1:0] l, inout logic [2:0] n, input rec_t r);
    if (n < 3'(MaxRecords)) begin
      l[n] = r;
      n = n + 3'd1;
    end
  endtask

  always_comb begin
    logic        chv, rerr, eoi, again, ok, is_dig, is_alpha;
    logic [7:0]  c, lead;
    logic [31:0] cb, b;
    logic [2:0]  nb, bc, wl;
    logic [4:0]  hd;
    logic [20:0] cp;
    logic [34:0] enc;
    logic [1:0]  wid;
    logic [3:0]  ntype;
    cb   = char_in.char_bytes;
    bc   = char_in.byte_count;
    eoi  = char_in.end_of_input;
    rerr = char_in.read_error;
    chv  = !eoi && !rerr && (bc == 3'd1);
    c    = cb[7:0];
    is_dig   = chv && c >= "0" && c <= "9";
    is_alpha = chv && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"));
    hd   = chv ? hex_digit(c) : 5'd0;
    lead = cb[7:0];
    scan_mode_next         = scan_mode;
    hex_accum_next         = hex_accum;
    hex_digit_count_next   = hex_digit_count;
    hex_all_valid_next     = hex_all_valid;
    number_lead_char_next  = number_lead_char;
    held_byte_next         = held_byte;
    held_valid_next        = held_valid;
    lone_zero_pending_next = lone_zero_pending;
    digits_seen_next       = digits_seen;
    is_fraction_next       = is_fraction;
    exp_sign_seen_next     = exp_sign_seen;
    word_progress_next     = word_progress;
    rec_list_next          = '0;
    rec_count_next         = 3'd0;
    again = 1'b1;
    ok    = 1'b0;
    cp    = 21'd0;
    b     = 32'd0;
    nb    = 3'd0;
    enc   = 35'd0;
    wid   = 2'd0;
    wl    = 3'd0;
    ntype = TOK_INTEGER;
    for (int p = 0; p < PassCount; p++) begin
      if (again) begin
        again = 1'b0;
        ntype = is_fraction_next ? TOK_FRACTION : TOK_INTEGER;
        case (scan_mode_next)
          MODE_STRING: begin
            if (rerr) push(rec_list_next, rec_count_next,
                           mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_READ));
            else if (eoi) begin
              push(rec_list_next, rec_count_next,
                   mk_rec(KIND_TOKEN, TOK_STRING, 32'd0, 3'd0, 5'd0));
              scan_mode_next = MODE_START;
              again = 1'b1;
            end else if (chv && c == "\"") begin
              push(rec_list_next, rec_count_next,
                   mk_rec(KIND_TOKEN, TOK_STRING, 32'd0, 3'd0, 5'd0));
              scan_mode_next = MODE_START;
            end else if (chv && c == "\\") begin
              scan_mode_next = MODE_ESCAPE;
            end else begin
              case (bc)
                3'd1: begin
                  ok = !lead[7];
                  cp = {14'd0, lead[6:0]};
                  b  = {24'd0, cb[7:0]};
                end
                3'd2: begin
                  ok = lead[7:5] == 3'b110 && cb[15:14] == 2'b10;
                  cp = {10'd0, lead[4:0], cb[13:8]};
                  b  = {16'd0, cb[15:0]};
                end
                3'd3: begin
                  ok = lead[7:4] == 4'b1110 && cb[15:14] == 2'b10 && cb[23:22] == 2'b10;
                  cp = {5'd0, lead[3:0], cb[13:8], cb[21:16]};
                  b  = {8'd0, cb[23:0]};
                end
                3'd4: begin
                  ok = lead[7:3] == 5'b11110 && cb[15:14] == 2'b10 && cb[23:22] == 2'b10
                       && cb[31:30] == 2'b10;
                  cp = {lead[2:0], cb[13:8], cb[21:16], cb[29:24]};
                  b  = cb;
                end
                default: begin
                  ok = 1'b0;
                  cp = 21'd0;
                  b  = 32'd0;
                end
              endcase
              if (!ok) push(rec_list_next, rec_count_next,
                            mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_BAD_UTF8));
              else if (cp < CpMin) push(rec_list_next, rec_count_next,
                            mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_BELOW_SPACE));
              else if ({3'd0, cp} > CpMax) push(rec_list_next, rec_count_next,
                            mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_ABOVE_MAX));
              else push(rec_list_next, rec_count_next,
                        mk_rec(KIND_VALUE, TOK_STRING, b, bc, 5'd0));
            end
          end
          MODE_ESCAPE: begin
            scan_mode_next = MODE_STRING;
            if (rerr) push(rec_list_next, rec_count_next,
                           mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_READ));
            else if (eoi) begin
              push(rec_list_next, rec_count_next,
                   mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_ESC_MISSING));
              again = 1'b1;
            end else if (!chv) push(rec_list_next, rec_count_next,
                           mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_ESC_INVALID));
            else begin
              case (c)
                "\"", "\\", "/": push(rec_list_next, rec_count_next,
                                      mk_rec(KIND_VALUE, TOK_STRING, {24'd0, c}, 3'd1, 5'd0));
                "b": push(rec_list_next, rec_count_next,
                          mk_rec(KIND_VALUE, TOK_STRING, 32'h08, 3'd1, 5'd0));
                "f": push(rec_list_next, rec_count_next,
                          mk_rec(KIND_VALUE, TOK_STRING, 32'h0C, 3'd1, 5'd0));
                "n": push(rec_list_next, rec_count_next,
                          mk_rec(KIND_VALUE, TOK_STRING, 32'h0A, 3'd1, 5'd0));
                "r": push(rec_list_next, rec_count_next,
                          mk_rec(KIND_VALUE, TOK_STRING, 32'h0D, 3'd1, 5'd0));
                "t": push(rec_list_next, rec_count_next,
                          mk_rec(KIND_VALUE, TOK_STRING, 32'h09, 3'd1, 5'd0));
                "u": begin
                  scan_mode_next       = MODE_UNICODE;
                  hex_accum_next       = 24'd0;
                  hex_digit_count_next = 3'd0;
                  hex_all_valid_next   = 1'b1;
                end
                default: push(rec_list_next, rec_count_next,
                              mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_ESC_INVALID));
              endcase
            end
          end
          MODE_UNICODE: begin
            ok = 1'b0;
            if (hex_digit_count_next < 3'd4) begin
              if (rerr) begin
                push(rec_list_next, rec_count_next,
                     mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_READ));
                hex_digit_count_next = hex_digit_count_next + 3'd1;
              end else if (eoi) begin
                push(rec_list_next, rec_count_next,
                     mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_UNI_UNFINISHED));
                scan_mode_next = MODE_STRING;
                again = 1'b1;
              end else begin
                if (hd[4]) hex_accum_next = {hex_accum_next[19:0], hd[3:0]};
                else begin
                  push(rec_list_next, rec_count_next,
                       mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_BAD_HEX));
                  hex_all_valid_next = 1'b0;
                end
                hex_digit_count_next = hex_digit_count_next + 3'd1;
              end
            end else if (rerr) begin
              push(rec_list_next, rec_count_next,
                   mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_READ));
              ok = 1'b1;
            end else if (eoi || !hd[4]) begin
              ok = 1'b1;
              again = 1'b1;
            end else begin
              hex_accum_next = {hex_accum_next[19:0], hd[3:0]};
              hex_digit_count_next = hex_digit_count_next + 3'd1;
              ok = hex_digit_count_next >= 3'd6;
            end
            if (ok) begin
              scan_mode_next = MODE_STRING;
              if (hex_all_valid_next) begin
                if (hex_accum_next < 24'h20) push(rec_list_next, rec_count_next,
                    mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_BELOW_SPACE));
                else if (hex_accum_next > CpMax) push(rec_list_next, rec_count_next,
                    mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_ABOVE_MAX));
                else begin
                  enc = utf8_encode(hex_accum_next[20:0]);
                  push(rec_list_next, rec_count_next,
                       mk_rec(KIND_VALUE, TOK_STRING, enc[31:0], enc[34:32], 5'd0));
                end
              end
            end
          end
          MODE_INT: begin
            b  = 32'd0;
            nb = 3'd0;
            ok = 1'b0;
            if (rerr) begin
              push(rec_list_next, rec_count_next,
                   mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_READ));
              ok = 1'b1;
            end else if (is_dig) begin
              if (lone_zero_pending_next) begin
                push(rec_list_next, rec_count_next,
                     mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_LEAD_ZERO));
                lone_zero_pending_next = 1'b0;
                if (c == "0") lone_zero_pending_next = 1'b1;
                else push(rec_list_next, rec_count_next,
                          mk_rec(KIND_VALUE, ntype, {24'd0, c}, 3'd1, 5'd0));
              end else if (!digits_seen_next) begin
                digits_seen_next = 1'b1;
                if (held_valid_next) begin
                  b  = {24'd0, held_byte_next};
                  nb = 3'd1;
                  held_valid_next = 1'b0;
                end
                if (c == "0") begin
                  lone_zero_pending_next = 1'b1;
                  if (nb != 3'd0) push(rec_list_next, rec_count_next,
                                       mk_rec(KIND_VALUE, ntype, b, nb, 5'd0));
                end else push(rec_list_next, rec_count_next,
                  mk_rec(KIND_VALUE, ntype, b | ({24'd0, c} << {nb, 3'b000}), nb + 3'd1, 5'd0));
              end else push(rec_list_next, rec_count_next,
                            mk_rec(KIND_VALUE, ntype, {24'd0, c}, 3'd1, 5'd0));
            end else if (chv && (c == "." || c == "e" || c == "E")) begin
              if (held_valid_next) begin
                b  = {24'd0, held_byte_next};
                nb = 3'd1;
                held_valid_next = 1'b0;
              end
              if (lone_zero_pending_next) begin
                b  = b | ({24'd0, 8'h30} << {nb, 3'b000});
                nb = nb + 3'd1;
                lone_zero_pending_next = 1'b0;
              end
              b  = b | ({24'd0, c} << {nb, 3'b000});
              nb = nb + 3'd1;
              is_fraction_next   = 1'b1;
              digits_seen_next   = 1'b0;
              exp_sign_seen_next = 1'b0;
              scan_mode_next     = (c == ".") ? MODE_FRAC : MODE_EXP;
              push(rec_list_next, rec_count_next,
                   mk_rec(KIND_VALUE, TOK_FRACTION, b, nb, 5'd0));
            end else begin
              ok = 1'b1;
              again = 1'b1;
            end
            if (ok) begin
              if (held_valid_next) begin
                push(rec_list_next, rec_count_next,
                     mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_LONE_SIGN));
                held_valid_next = 1'b0;
                push(rec_list_next, rec_count_next,
                     mk_rec(KIND_VALUE, ntype, 32'h30, 3'd1, 5'd0));
              end else if (lone_zero_pending_next) push(rec_list_next, rec_count_next,
                     mk_rec(KIND_VALUE, ntype, 32'h30, 3'd1, 5'd0));
              lone_zero_pending_next = 1'b0;
              push(rec_list_next, rec_count_next,
                   mk_rec(KIND_TOKEN, TOK_INTEGER, 32'd0, 3'd0, 5'd0));
              scan_mode_next = MODE_START;
            end
          end
          MODE_FRAC: begin
            if (rerr || (!is_dig && !(chv && (c == "e" || c == "E")))) begin
              if (rerr) push(rec_list_next, rec_count_next,
                             mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_READ));
              if (!digits_seen_next) push(rec_list_next, rec_count_next,
                             mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_FRAC_NODIG));
              push(rec_list_next, rec_count_next,
                   mk_rec(KIND_TOKEN, TOK_FRACTION, 32'd0, 3'd0, 5'd0));
              scan_mode_next = MODE_START;
              again = !rerr;
            end else begin
              push(rec_list_next, rec_count_next,
                   mk_rec(KIND_VALUE, ntype, {24'd0, c}, 3'd1, 5'd0));
              if (is_dig) digits_seen_next = 1'b1;
              else begin
                scan_mode_next     = digits_seen_next ? MODE_EXP : MODE_EXP_NOFRAC;
                digits_seen_next   = 1'b0;
                exp_sign_seen_next = 1'b0;
              end
            end
          end
          MODE_EXP, MODE_EXP_NOFRAC: begin
            if (chv && (c == "+" || c == "-")) begin
              if (digits_seen_next) push(rec_list_next, rec_count_next,
                  mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_EXP_LATE_SIGN));
              else if (exp_sign_seen_next) push(rec_list_next, rec_count_next,
                  mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_EXP_TWO_SIGNS));
              else begin
                exp_sign_seen_next = 1'b1;
                push(rec_list_next, rec_count_next,
                     mk_rec(KIND_VALUE, ntype, {24'd0, c}, 3'd1, 5'd0));
              end
            end else if (is_dig) begin
              digits_seen_next = 1'b1;
              push(rec_list_next, rec_count_next,
                   mk_rec(KIND_VALUE, ntype, {24'd0, c}, 3'd1, 5'd0));
            end else begin
              if (rerr) push(rec_list_next, rec_count_next,
                             mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_READ));
              if (!digits_seen_next) push(rec_list_next, rec_count_next,
                             mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_EXP_NODIG));
              if (scan_mode_next == MODE_EXP_NOFRAC) push(rec_list_next, rec_count_next,
                             mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_FRAC_NODIG));
              push(rec_list_next, rec_count_next,
                   mk_rec(KIND_TOKEN, TOK_FRACTION, 32'd0, 3'd0, 5'd0));
              scan_mode_next = MODE_START;
              again = !rerr;
            end
          end
          MODE_WORD: begin
            wid = word_progress_next[4:3];
            wl  = word_len(wid);
            if (is_alpha) begin
              if (wid != 2'd0 && word_progress_next[2:0] < wl
                  && word_char(wid, word_progress_next[2:0]) == c)
                word_progress_next = {wid, word_progress_next[2:0] + 3'd1};
              else word_progress_next = 5'd0;
            end else begin
              if (rerr) push(rec_list_next, rec_count_next,
                             mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_READ));
              if (wid != 2'd0 && word_progress_next[2:0] == wl)
                push(rec_list_next, rec_count_next,
                     mk_rec(KIND_TOKEN, TOK_WORD_BASE + {2'd0, wid}, 32'd0, 3'd0, 5'd0));
              else push(rec_list_next, rec_count_next,
                        mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_BAD_WORD));
              word_progress_next = 5'd0;
              scan_mode_next     = MODE_START;
              again = !rerr;
            end
          end
          default: begin
            scan_mode_next = MODE_START;
            if (rerr) push(rec_list_next, rec_count_next,
                           mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_READ));
            else if (eoi) push(rec_list_next, rec_count_next,
                               mk_rec(KIND_TOKEN, TOK_EOF, 32'd0, 3'd0, 5'd0));
            else if (!chv) push(rec_list_next, rec_count_next,
                                mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_BAD_CHAR));
            else if (c == "\"") scan_mode_next = MODE_STRING;
            else if (is_dig || c == "-" || c == "+" || c == ".") begin
              scan_mode_next         = MODE_INT;
              number_lead_char_next  = c;
              held_valid_next        = 1'b0;
              lone_zero_pending_next = 1'b0;
              digits_seen_next       = 1'b0;
              is_fraction_next       = 1'b0;
              exp_sign_seen_next     = 1'b0;
              if (c == ".") begin
                is_fraction_next = 1'b1;
                scan_mode_next   = MODE_FRAC;
                push(rec_list_next, rec_count_next,
                     mk_rec(KIND_VALUE, TOK_FRACTION, 32'h2E, 3'd1, 5'd0));
                push(rec_list_next, rec_count_next,
                     mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_LEAD_PERIOD));
              end else if (c == "0") begin
                lone_zero_pending_next = 1'b1;
                digits_seen_next       = 1'b1;
              end else if (is_dig) begin
                digits_seen_next = 1'b1;
                push(rec_list_next, rec_count_next,
                     mk_rec(KIND_VALUE, TOK_INTEGER, {24'd0, c}, 3'd1, 5'd0));
              end else begin
                held_byte_next  = c;
                held_valid_next = 1'b1;
                if (c == "+") push(rec_list_next, rec_count_next,
                                   mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_LEAD_PLUS));
              end
            end else if (is_alpha) begin
              scan_mode_next = MODE_WORD;
              if (c == "t") word_progress_next = 5'h09;
              else if (c == "f") word_progress_next = 5'h11;
              else if (c == "n") word_progress_next = 5'h19;
              else word_progress_next = 5'h00;
            end else begin
              case (c)
                " ", 8'h09, 8'h0D, 8'h0A: ;
                "[": push(rec_list_next, rec_count_next,
                          mk_rec(KIND_TOKEN, TOK_LBRACKET, 32'd0, 3'd0, 5'd0));
                "]": push(rec_list_next, rec_count_next,
                          mk_rec(KIND_TOKEN, TOK_RBRACKET, 32'd0, 3'd0, 5'd0));
                ",": push(rec_list_next, rec_count_next,
                          mk_rec(KIND_TOKEN, TOK_COMMA, 32'd0, 3'd0, 5'd0));
                "{": push(rec_list_next, rec_count_next,
                          mk_rec(KIND_TOKEN, TOK_LBRACE, 32'd0, 3'd0, 5'd0));
                "}": push(rec_list_next, rec_count_next,
                          mk_rec(KIND_TOKEN, TOK_RBRACE, 32'd0, 3'd0, 5'd0));
                ":": push(rec_list_next, rec_count_next,
                          mk_rec(KIND_TOKEN, TOK_COLON, 32'd0, 3'd0, 5'd0));
                default: push(rec_list_next, rec_count_next,
                              mk_rec(KIND_ERROR, TOK_NONE, 32'd0, 3'd0, ERR_BAD_CHAR));
              endcase
            end
          end
        endcase
      end
    end
  end

  assign rec_out.valid       = rec_idx < rec_count;
  assign rec_out.record_kind = rec_list[rec_idx].kind;
  assign rec_out.token_type  = rec_list[rec_idx].ttype;
  assign rec_out.value_bytes = rec_list[rec_idx].bytes;
  assign rec_out.value_count = rec_list[rec_idx].cnt;
  assign rec_out.error_code  = rec_list[rec_idx].code;
  assign rec_out.last        = rec_idx == rec_count - 3'd1;

  assign take          = rec_out.valid && rec_out.ready;
  assign char_in.ready = !rec_out.valid || (take && rec_out.last);
  assign accept        = char_in.valid && char_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode         <= MODE_START;
      hex_accum         <= 24'd0;
      hex_digit_count   <= 3'd0;
      hex_all_valid     <= 1'b1;
      number_lead_char  <= 8'd0;
      held_byte         <= 8'd0;
      held_valid        <= 1'b0;
      lone_zero_pending <= 1'b0;
      digits_seen       <= 1'b0;
      is_fraction       <= 1'b0;
      exp_sign_seen     <= 1'b0;
      word_progress     <= 5'd0;
      rec_count         <= 3'd0;
      rec_idx           <= 3'd0;
    end else if (accept) begin
      scan_mode         <= scan_mode_next;
      hex_accum         <= hex_accum_next;
      hex_digit_count   <= hex_digit_count_next;
      hex_all_valid     <= hex_all_valid_next;
      number_lead_char  <= number_lead_char_next;
      held_byte         <= held_byte_next;
      held_valid        <= held_valid_next;
      lone_zero_pending <= lone_zero_pending_next;
      digits_seen       <= digits_seen_next;
      is_fraction       <= is_fraction_next;
      exp_sign_seen     <= exp_sign_seen_next;
      word_progress     <= word_progress_next;
      rec_count         <= rec_count_next;
      rec_idx           <= 3'd0;
    end else if (take) begin
      rec_idx <= rec_idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rec_list <= rec_list_next;
    end
  end

endmodule

[sim/tb_json_token_scanner_core.sv]
// ----------------------------------------------------------------------------
// tb_json_token_scanner_core
// Self-checking bench for the JSON token scanner: a directed table of characters,
// then random JSON-like text mixed with noise, each record compared against a
// typed-in table record or a behavioral lexer running alongside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_json_token_scanner_core;
  import jts_pkg::*;

  localparam int StallLimit = 2000;
  localparam int MaxShown   = 10;

  typedef struct {
    logic [31:0] bytes;
    logic [2:0]  cnt;
    logic        eoi;
    logic        rerr;
  } char_t;

  typedef struct {
    logic [1:0]  kind;
    logic [3:0]  ttype;
    logic [31:0] bytes;
    logic [2:0]  cnt;
    logic [4:0]  code;
    logic        last;
  } record_t;

  // directed row: character plus an optional typed-in single record
  typedef struct {
    char_t   c;
    logic    typed;
    record_t r;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  jts_in_if  char_in ();
  jts_out_if rec_out ();

  json_token_scanner_core DUT (
    .clk     (clk),
    .rst     (rst),
    .char_in (char_in.sink),
    .rec_out (rec_out.source)
  );

  always #5 clk = ~clk;

  // scanner state of the behavioral lexer
  mode_t       s_mode;
  logic [23:0] s_hex;
  logic [2:0]  s_hcnt;
  logic        s_hok;
  logic [7:0]  s_held;
  logic        s_held_v;
  logic        s_zero;
  logic        s_digits;
  logic        s_frac;
  logic        s_esign;
  logic [4:0]  s_word;

  record_t expected_records[$];
  record_t step_recs[$];
  char_t   char_queue[$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  bit      stim_done = 0;
  bit      hold_off = 0;
  bit      c_eoi, c_rerr;
  int      c_ch;

  function automatic record_t mk(logic [1:0] k, logic [3:0] t, logic [31:0] b,
                                 logic [2:0] n, logic [4:0] e);
    record_t r;
    r.kind = k; r.ttype = t; r.bytes = b; r.cnt = n; r.code = e; r.last = 1'b0;
    return r;
  endfunction

  function automatic bit is_digit(int c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(int c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic int hex_of(int c);
    if (is_digit(c)) return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic logic [7:0] letter_at(int id, int pos);
    string w;
    if (id == 1) w = "true";
    else if (id == 2) w = "false";
    else if (id == 3) w = "null";
    else w = "";
    return pos < w.len() ? w[pos] : 8'h00;
  endfunction

  function automatic int word_length(int id);
    return id == 2 ? 5 : id == 0 ? 0 : 4;
  endfunction

  task automatic push(logic [1:0] k, logic [3:0] t, logic [31:0] b, logic [2:0] n,
                      logic [4:0] e);
    if (step_recs.size() < MaxRecords) step_recs.push_back(mk(k, t, b, n, e));
  endtask

  task automatic fail(logic [4:0] e);
    push(KIND_ERROR, TOK_NONE, 0, 0, e);
  endtask

  task automatic num_bytes(logic [31:0] b, logic [2:0] n);
    push(KIND_VALUE, s_frac ? TOK_FRACTION : TOK_INTEGER, b, n, 0);
  endtask

  task automatic emit_code_point();
    logic [23:0] cp;
    logic [31:0] b;
    logic [2:0]  n;
    cp = s_hex;
    if (!s_hok) return;
    if (cp < 24'h20) begin fail(ERR_BELOW_SPACE); return; end
    if (cp > 24'h10FFFF) begin fail(ERR_ABOVE_MAX); return; end
    if (cp < 24'h80) begin b = cp; n = 1; end
    else if (cp < 24'h800) begin
      b = {16'h0, 2'b10, cp[5:0], 3'b110, cp[10:6]}; n = 2;
    end else if (cp < 24'h10000) begin
      b = {8'h0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]}; n = 3;
    end else begin
      b = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110, cp[20:18]};
      n = 4;
    end
    push(KIND_VALUE, TOK_STRING, b, n, 0);
  endtask

  task automatic end_integer();
    if (s_held_v) begin
      fail(ERR_LONE_SIGN); s_held_v = 0; num_bytes("0", 1);
    end else if (s_zero) num_bytes("0", 1);
    s_zero = 0;
    push(KIND_TOKEN, TOK_INTEGER, 0, 0, 0);
    s_mode = MODE_START;
  endtask

  task automatic scan_start();
    s_mode = MODE_START;
    if (c_rerr) fail(ERR_READ);
    else if (c_eoi) push(KIND_TOKEN, TOK_EOF, 0, 0, 0);
    else if (c_ch < 0) fail(ERR_BAD_CHAR);
    else if (c_ch == "\"") s_mode = MODE_STRING;
    else if (c_ch == "-" || c_ch == "+" || c_ch == "." || is_digit(c_ch)) begin
      s_mode = MODE_INT;
      s_held_v = 0; s_zero = 0; s_digits = 0; s_frac = 0; s_esign = 0;
      if (c_ch == ".") begin
        s_frac = 1; s_mode = MODE_FRAC; num_bytes(".", 1); fail(ERR_LEAD_PERIOD);
      end else if (c_ch == "0") begin
        s_zero = 1; s_digits = 1;
      end else if (is_digit(c_ch)) begin
        s_digits = 1; num_bytes(c_ch, 1);
      end else begin
        s_held = c_ch; s_held_v = 1;
        if (c_ch == "+") fail(ERR_LEAD_PLUS);
      end
    end else if (is_letter(c_ch)) begin
      s_mode = MODE_WORD;
      s_word = c_ch == "t" ? 5'h09 : c_ch == "f" ? 5'h11 : c_ch == "n" ? 5'h19 : 5'h00;
    end else
      case (c_ch)
        " ", "\t", "\r", "\n": ;
        "[": push(KIND_TOKEN, TOK_LBRACKET, 0, 0, 0);
        "]": push(KIND_TOKEN, TOK_RBRACKET, 0, 0, 0);
        ",": push(KIND_TOKEN, TOK_COMMA, 0, 0, 0);
        "{": push(KIND_TOKEN, TOK_LBRACE, 0, 0, 0);
        "}": push(KIND_TOKEN, TOK_RBRACE, 0, 0, 0);
        ":": push(KIND_TOKEN, TOK_COLON, 0, 0, 0);
        default: fail(ERR_BAD_CHAR);
      endcase
  endtask

  task automatic scan_string(char_t c, output bit again);
    logic [7:0]  lead, b;
    logic [31:0] cp;
    int          n;
    again = 0;
    n = c.cnt;
    lead = c.bytes[7:0];
    if (c_rerr) begin fail(ERR_READ); return; end
    if (c_eoi) begin
      push(KIND_TOKEN, TOK_STRING, 0, 0, 0); s_mode = MODE_START; again = 1; return;
    end
    if (c_ch == "\"") begin
      push(KIND_TOKEN, TOK_STRING, 0, 0, 0); s_mode = MODE_START; return;
    end
    if (c_ch == "\\") begin s_mode = MODE_ESCAPE; return; end
    if (n == 1 && lead < 8'h80) cp = lead;
    else if (n == 2 && lead[7:5] == 3'b110) cp = lead[4:0];
    else if (n == 3 && lead[7:4] == 4'b1110) cp = lead[3:0];
    else if (n == 4 && lead[7:3] == 5'b11110) cp = lead[2:0];
    else begin fail(ERR_BAD_UTF8); return; end
    for (int i = 1; i < n; i++) begin
      b = c.bytes[8*i +: 8];
      if (b[7:6] != 2'b10) begin fail(ERR_BAD_UTF8); return; end
      cp = (cp << 6) | b[5:0];
    end
    if (cp < 32'h20) fail(ERR_BELOW_SPACE);
    else if (cp > 32'h10FFFF) fail(ERR_ABOVE_MAX);
    else push(KIND_VALUE, TOK_STRING, n < 4 ? c.bytes & ((32'd1 << (8*n)) - 1) : c.bytes,
              n, 0);
  endtask

  task automatic scan_escape(output bit again);
    logic [7:0] o;
    again = 0;
    s_mode = MODE_STRING;
    if (c_rerr) begin fail(ERR_READ); return; end
    if (c_eoi) begin fail(ERR_ESC_MISSING); again = 1; return; end
    case (c_ch)
      "\"", "\\", "/": o = c_ch;
      "b": o = 8'h08;
      "f": o = 8'h0C;
      "n": o = 8'h0A;
      "r": o = 8'h0D;
      "t": o = 8'h09;
      "u": begin
        s_mode = MODE_UNICODE; s_hex = 0; s_hcnt = 0; s_hok = 1; return;
      end
      default: begin fail(ERR_ESC_INVALID); return; end
    endcase
    push(KIND_VALUE, TOK_STRING, o, 1, 0);
  endtask

  task automatic scan_unicode(output bit again);
    int d;
    again = 0;
    d = c_ch < 0 ? -1 : hex_of(c_ch);
    if (s_hcnt < 4) begin
      if (c_rerr) begin fail(ERR_READ); s_hcnt++; return; end
      if (c_eoi) begin fail(ERR_UNI_UNFINISHED); s_mode = MODE_STRING; again = 1; return; end
      if (d >= 0) s_hex = {s_hex[19:0], 4'(d)};
      else begin fail(ERR_BAD_HEX); s_hok = 0; end
      s_hcnt++;
      return;
    end
    if (c_rerr) begin
      fail(ERR_READ); emit_code_point(); s_mode = MODE_STRING; return;
    end
    if (c_eoi || d < 0) begin
      emit_code_point(); s_mode = MODE_STRING; again = 1; return;
    end
    s_hex = {s_hex[19:0], 4'(d)};
    s_hcnt++;
    if (s_hcnt >= 6) begin emit_code_point(); s_mode = MODE_STRING; end
  endtask

  task automatic scan_int(output bit again);
    logic [31:0] b;
    int          n;
    again = 0; b = 0; n = 0;
    if (c_rerr) begin fail(ERR_READ); end_integer(); return; end
    if (is_digit(c_ch)) begin
      if (s_zero) begin
        fail(ERR_LEAD_ZERO); s_zero = 0;
        if (c_ch == "0") s_zero = 1; else num_bytes(c_ch, 1);
      end else if (!s_digits) begin
        s_digits = 1;
        if (s_held_v) begin b = s_held; n = 1; s_held_v = 0; end
        if (c_ch == "0") begin
          s_zero = 1; if (n != 0) num_bytes(b, n);
        end else num_bytes(b | (c_ch << (8*n)), n + 1);
      end else num_bytes(c_ch, 1);
      return;
    end
    if (c_ch == "." || c_ch == "e" || c_ch == "E") begin
      if (s_held_v) begin b = s_held; n = 1; s_held_v = 0; end
      if (s_zero) begin b |= 32'h30 << (8*n); n++; s_zero = 0; end
      b |= c_ch << (8*n); n++;
      s_frac = 1; s_digits = 0; s_esign = 0;
      s_mode = c_ch == "." ? MODE_FRAC : MODE_EXP;
      num_bytes(b, n);
      return;
    end
    end_integer();
    again = 1;
  endtask

  task automatic scan_frac(output bit again);
    again = 0;
    if (c_rerr || (!is_digit(c_ch) && c_ch != "e" && c_ch != "E")) begin
      if (c_rerr) fail(ERR_READ);
      if (!s_digits) fail(ERR_FRAC_NODIG);
      push(KIND_TOKEN, TOK_FRACTION, 0, 0, 0); s_mode = MODE_START;
      again = !c_rerr;
      return;
    end
    num_bytes(c_ch, 1);
    if (is_digit(c_ch)) begin s_digits = 1; return; end
    s_mode = s_digits ? MODE_EXP : MODE_EXP_NOFRAC;
    s_digits = 0; s_esign = 0;
  endtask

  task automatic scan_exp(output bit again);
    again = 0;
    if (!c_rerr && (c_ch == "+" || c_ch == "-")) begin
      if (s_digits) fail(ERR_EXP_LATE_SIGN);
      else if (s_esign) fail(ERR_EXP_TWO_SIGNS);
      else begin s_esign = 1; num_bytes(c_ch, 1); end
      return;
    end
    if (!c_rerr && is_digit(c_ch)) begin s_digits = 1; num_bytes(c_ch, 1); return; end
    if (c_rerr) fail(ERR_READ);
    if (!s_digits) fail(ERR_EXP_NODIG);
    if (s_mode == MODE_EXP_NOFRAC) fail(ERR_FRAC_NODIG);
    push(KIND_TOKEN, TOK_FRACTION, 0, 0, 0); s_mode = MODE_START;
    again = !c_rerr;
  endtask

  task automatic scan_word(output bit again);
    int id, len;
    again = 0;
    id = s_word[4:3]; len = s_word[2:0];
    if (!c_rerr && is_letter(c_ch)) begin
      if (id != 0 && len < word_length(id) && letter_at(id, len) == c_ch)
        s_word = {2'(id), 3'(len + 1)};
      else s_word = 0;
      return;
    end
    if (c_rerr) fail(ERR_READ);
    if (id != 0 && len == word_length(id)) push(KIND_TOKEN, TOK_WORD_BASE + id, 0, 0, 0);
    else fail(ERR_BAD_WORD);
    s_word = 0; s_mode = MODE_START;
    again = !c_rerr;
  endtask

  task automatic lexer_reset();
    s_mode = MODE_START; s_hex = 0; s_hcnt = 0; s_hok = 1; s_held = 0; s_held_v = 0;
    s_zero = 0; s_digits = 0; s_frac = 0; s_esign = 0; s_word = 0;
  endtask

  // run one character through the lexer, leave its records in step_recs
  task automatic lex_char(char_t c);
    bit again;
    int passes;
    again = 1; passes = 0;
    step_recs.delete();
    c_eoi = c.eoi; c_rerr = c.rerr;
    c_ch = (!c.eoi && !c.rerr && c.cnt == 1) ? int'(c.bytes[7:0]) : -1;
    while (again && passes < PassCount) begin
      passes++;
      case (s_mode)
        MODE_STRING:                begin scan_string(c, again); end
        MODE_ESCAPE:                begin scan_escape(again); end
        MODE_UNICODE:               begin scan_unicode(again); end
        MODE_INT:                   begin scan_int(again); end
        MODE_FRAC:                  begin scan_frac(again); end
        MODE_EXP, MODE_EXP_NOFRAC:  begin scan_exp(again); end
        MODE_WORD:                  begin scan_word(again); end
        default:                    begin scan_start(); again = 0; end
      endcase
    end
    if (step_recs.size() > 0) step_recs[step_recs.size()-1].last = 1'b1;
  endtask

  function automatic char_t ascii(int c);
    char_t x;
    x.bytes = c; x.cnt = 1; x.eoi = 0; x.rerr = 0;
    return x;
  endfunction

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) char_queue.push_back(ascii(s[i]));
  endtask

  // one random character of s, as a string
  function automatic string pick(string s);
    int i;
    i = $urandom_range(0, s.len() - 1);
    return s.substr(i, i);
  endfunction

  function automatic char_t raw(logic [31:0] b, logic [2:0] n, bit e, bit r);
    char_t x;
    x.bytes = b; x.cnt = n; x.eoi = e; x.rerr = r;
    return x;
  endfunction

  // random multi-byte character that passes the structure check
  function automatic char_t utf8_char();
    int n;
    logic [31:0] b;
    n = $urandom_range(2, 4);
    b = $urandom;
    for (int i = 1; i < 4; i++) b[8*i+7 -: 2] = 2'b10;
    case (n)
      2: b[7:5] = 3'b110;
      3: b[7:4] = 4'b1110;
      default: b[7:3] = 5'b11110;
    endcase
    return raw(b, n, 0, 0);
  endfunction

  task automatic add_random_token();
    string digs;
    case ($urandom_range(0, 9))
      0, 1: begin
        char_queue.push_back(ascii("\""));
        repeat ($urandom_range(0, 5))
          case ($urandom_range(0, 5))
            0: char_queue.push_back(utf8_char());
            1: add_text($urandom_range(0, 1) ? "\\n" : "\\\"");
            2: begin
              add_text("\\u");
              repeat ($urandom_range(3, 7)) add_text(pick("0123456789abcDEFxg"));
            end
            default: char_queue.push_back(ascii($urandom_range(32'h20, 32'h7E)));
          endcase
        if ($urandom_range(0, 5) != 0) char_queue.push_back(ascii("\""));
      end
      2, 3, 4: begin
        digs = "";
        if ($urandom_range(0, 2) == 0) digs = {digs, pick("-+")};
        repeat ($urandom_range(0, 3)) digs = {digs, pick("0123456789")};
        if ($urandom_range(0, 1)) digs = {digs, ".5"};
        if ($urandom_range(0, 2) == 0) digs = {digs, pick("e-+7"), "3"};
        add_text(digs);
      end
      5: begin
        if ($urandom_range(0, 1)) add_text("true");
        else if ($urandom_range(0, 1)) add_text("false");
        else add_text("nul");
      end
      6: add_text(pick("[]{},:"));
      7: char_queue.push_back(raw($urandom, $urandom_range(0, 7), 0, $urandom_range(0, 3) == 0));
      default: char_queue.push_back(ascii($urandom_range(0, 255)));
    endcase
    if ($urandom_range(0, 1)) add_text(pick(" ,"));
  endtask

  // directed table
  row_t dir_rows[$];

  task automatic row(char_t c, bit typed, logic [1:0] k = 0, logic [3:0] t = 0,
                     logic [4:0] e = 0);
    row_t r;
    r.c = c; r.typed = typed; r.r = mk(k, t, 0, 0, e); r.r.last = 1'b1;
    dir_rows.push_back(r);
  endtask

  task automatic build_table();
    row(ascii("["), 1, KIND_TOKEN, TOK_LBRACKET);
    row(ascii(":"), 1, KIND_TOKEN, TOK_COLON);
    row(raw(32'hFFFFFFFF, 4, 0, 0), 1, KIND_ERROR, TOK_NONE, ERR_BAD_CHAR);
    row(raw(32'h0, 1, 0, 1), 1, KIND_ERROR, TOK_NONE, ERR_READ);
    row(ascii("\""), 0);
    row(raw(32'hBFBFBFF7, 4, 0, 0), 1, KIND_ERROR, TOK_NONE, ERR_ABOVE_MAX);
    row(ascii(8'h01), 1, KIND_ERROR, TOK_NONE, ERR_BELOW_SPACE);
    row(raw(32'h0, 0, 0, 0), 1, KIND_ERROR, TOK_NONE, ERR_BAD_UTF8);
    row(ascii("\\"), 0);
    row(ascii("q"), 1, KIND_ERROR, TOK_NONE, ERR_ESC_INVALID);
    row(ascii("\\"), 0);
    row(ascii("u"), 0);
    row(ascii("D"), 0);
    row(ascii("8"), 0);
    row(ascii("0"), 0);
    row(ascii("1"), 0);
    row(ascii("\""), 0);
    row(ascii("0"), 0);
    row(ascii("5"), 0);
    row(ascii("+"), 0);
    row(ascii("."), 0);
    row(ascii("e"), 0);
    row(ascii("x"), 0);
    row(ascii(" "), 0);
    row(raw(32'hFFFFFFFF, 7, 1, 0), 1, KIND_TOKEN, TOK_EOF);
  endtask

  // sender: bursts with random gaps
  task automatic send_char(char_t c);
    char_in.valid <= 1'b1;
    char_in.char_bytes <= c.bytes;
    char_in.byte_count <= c.cnt;
    char_in.end_of_input <= c.eoi;
    char_in.read_error <= c.rerr;
    do @(posedge clk); while (!char_in.ready);
    @(negedge clk);
  endtask

  int burst_left = 0;

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        char_in.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  initial begin
    row_t  r;
    char_t c;
    char_in.valid = 0; char_in.char_bytes = 0; char_in.byte_count = 1;
    char_in.end_of_input = 0; char_in.read_error = 0;
    lexer_reset();
    build_table();
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      lex_char(r.c);
      if (r.typed) begin
        expected_records.push_back(r.r);
      end else
        foreach (step_recs[j]) expected_records.push_back(step_recs[j]);
      pace();
      send_char(r.c);
    end
    while (char_queue.size() < 85) add_random_token();
    foreach (char_queue[i]) begin
      lex_char(char_queue[i]);
      foreach (step_recs[j]) expected_records.push_back(step_recs[j]);
      if (i == 40) hold_off = 1;
      pace();
      send_char(char_queue[i]);
    end
    c = raw(0, 1, 1, 0);
    lex_char(c);
    foreach (step_recs[j]) expected_records.push_back(step_recs[j]);
    send_char(c);
    char_in.valid <= 1'b0;
    stim_done = 1;
  end

  // receiver: own stall pattern plus one long hold-off
  initial begin
    rec_out.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        rec_out.ready <= 1'b0;
        repeat (60) @(negedge clk);
        hold_off = 0;
      end
      rec_out.ready <= ($urandom_range(0, 15) < 11) || ($urandom_range(0, 63) == 0);
      @(negedge clk);
    end
  end

  // compare accepted records
  always @(posedge clk) begin
    record_t want;
    if (!rst && rec_out.valid && rec_out.ready) begin
      if (expected_records.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("unexpected record kind=%0d type=%0d bytes=%h cnt=%0d err=%0d",
                   rec_out.record_kind, rec_out.token_type, rec_out.value_bytes,
                   rec_out.value_count, rec_out.error_code);
      end else begin
        want = expected_records.pop_front();
        if (rec_out.record_kind !== want.kind || rec_out.token_type !== want.ttype ||
            rec_out.value_bytes !== want.bytes || rec_out.value_count !== want.cnt ||
            rec_out.error_code !== want.code || rec_out.last !== want.last) begin
          mismatches++;
          if (mismatches <= MaxShown)
            $display("mismatch exp %0d/%0d/%h/%0d/%0d/%0d got %0d/%0d/%h/%0d/%0d/%0d",
                     want.kind, want.ttype, want.bytes, want.cnt, want.code, want.last,
                     rec_out.record_kind, rec_out.token_type, rec_out.value_bytes,
                     rec_out.value_count, rec_out.error_code, rec_out.last);
        end
      end
    end
  end

  // watchdog on transaction-free cycles
  always @(posedge clk) begin
    if ((char_in.valid && char_in.ready) || (rec_out.valid && rec_out.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    wait (stim_done && expected_records.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_records.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
